@@ hdl/hsm_pkg.sv @@
// ----------------------------------------------------------------------------
// hsm_pkg: shared types and constants
// Register indexes, reset values, request and status codes, and the result
// and configuration records passed between the blocks of the bus master.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int CMD_W      = 8;
  localparam int LIMIT_W    = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int VALUE_W    = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CMD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_CMD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CMD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [CMD_W-1:0]   RST_TEMP_CMD    = 8'd3;
  localparam logic [CMD_W-1:0]   RST_HUMID_CMD   = 8'd5;
  localparam logic [CMD_W-1:0]   RST_STATUS_CMD  = 8'd7;
  localparam logic [LIMIT_W-1:0] RST_TEMP_LIMIT  = 18'd175000;
  localparam logic [LIMIT_W-1:0] RST_HUMID_LIMIT = 18'd50000;

  // input opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // request kinds
  localparam logic [1:0] KIND_TEMP    = 2'd0;
  localparam logic [1:0] KIND_HUMID   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // transaction status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ACK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   temp_command;
    logic [CMD_W-1:0]   humid_command;
    logic [CMD_W-1:0]   status_command;
    logic [LIMIT_W-1:0] temp_wait_limit;
    logic [LIMIT_W-1:0] humid_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic               sck_out;
    logic               data_release;
    logic               busy_res;
    logic               done_res;
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status_code;
  } result_t;

endpackage

@@ hdl/hsm_if.sv @@
// ----------------------------------------------------------------------------
// hsm_if: stream channels of the bus master
// Valid/ready channels for tick and request items in, and line/result items out.
// ----------------------------------------------------------------------------
interface hsm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] request_kind;
  logic       data_in;

  modport source (output valid, output opcode, output request_kind, output data_in,
                  input ready);
  modport sink   (input valid, input opcode, input request_kind, input data_in,
                  output ready);
endinterface

interface hsm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sck_out;
  logic                        data_release;
  logic                        busy_res;
  logic                        done_res;
  logic [hsm_pkg::VALUE_W-1:0] read_value;
  logic [1:0]                  status_code;

  modport source (output valid, output sck_out, output data_release, output busy_res,
                  output done_res, output read_value, output status_code,
                  input ready);
  modport sink   (input valid, input sck_out, input data_release, input busy_res,
                  input done_res, input read_value, input status_code,
                  output ready);
endinterface

@@ hdl/hsm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hsm_cfg_regs: configuration registers
// Command bytes and conversion wait limits, written through a plain write port.
// ----------------------------------------------------------------------------
module hsm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output hsm_pkg::cfg_t                    cfg
);

  hsm_pkg::cfg_t cfg_r;
  hsm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hsm_pkg::CFG_TEMP_CMD:    cfg_nxt.temp_command     = cfg_wdata[hsm_pkg::CMD_W-1:0];
        hsm_pkg::CFG_HUMID_CMD:   cfg_nxt.humid_command    = cfg_wdata[hsm_pkg::CMD_W-1:0];
        hsm_pkg::CFG_STATUS_CMD:  cfg_nxt.status_command   = cfg_wdata[hsm_pkg::CMD_W-1:0];
        hsm_pkg::CFG_TEMP_LIMIT:  cfg_nxt.temp_wait_limit  = cfg_wdata[hsm_pkg::LIMIT_W-1:0];
        hsm_pkg::CFG_HUMID_LIMIT: cfg_nxt.humid_wait_limit = cfg_wdata[hsm_pkg::LIMIT_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_command     <= hsm_pkg::RST_TEMP_CMD;
      cfg_r.humid_command    <= hsm_pkg::RST_HUMID_CMD;
      cfg_r.status_command   <= hsm_pkg::RST_STATUS_CMD;
      cfg_r.temp_wait_limit  <= hsm_pkg::RST_TEMP_LIMIT;
      cfg_r.humid_wait_limit <= hsm_pkg::RST_HUMID_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/hsm_seq.sv @@
// ----------------------------------------------------------------------------
// hsm_seq: bus phase sequencer
// Holds the transaction state and, for each accepted item, forms the line
// levels of the current phase and advances at most one half-bit phase.
// ----------------------------------------------------------------------------
module hsm_seq #(
  parameter int WAIT_BITS        = 18,
  parameter int START_LEAD_TICKS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               opcode,
  input  logic [1:0]         request_kind,
  input  logic               data_in,
  input  hsm_pkg::cfg_t      cfg,
  output hsm_pkg::result_t   res
);

  localparam int CW = (WAIT_BITS > hsm_pkg::LIMIT_W) ? WAIT_BITS : hsm_pkg::LIMIT_W;
  localparam logic [WAIT_BITS-1:0] LEAD_TICKS = WAIT_BITS'(START_LEAD_TICKS);
  localparam logic [WAIT_BITS-1:0] WAIT_MAX   = {WAIT_BITS{1'b1}};

  typedef enum logic [17:0] {
    PH_IDLE    = 18'h00001,
    PH_LEAD    = 18'h00002,
    PH_S1      = 18'h00004,
    PH_S2      = 18'h00008,
    PH_S3      = 18'h00010,
    PH_S4      = 18'h00020,
    PH_S5      = 18'h00040,
    PH_S6      = 18'h00080,
    PH_SEND_LO = 18'h00100,
    PH_SEND_HI = 18'h00200,
    PH_ACK_LO  = 18'h00400,
    PH_ACK_HI  = 18'h00800,
    PH_WAIT    = 18'h01000,
    PH_RECV_LO = 18'h02000,
    PH_RECV_HI = 18'h04000,
    PH_RACK_LO = 18'h08000,
    PH_RACK_HI = 18'h10000,
    PH_STOP    = 18'h20000
  } phase_t;

  phase_t                      phase_r,      phase_nxt;
  logic [3:0]                  bit_count_r,  bit_count_nxt;
  logic [7:0]                  shift_r,      shift_nxt;
  logic [1:0]                  byte_index_r, byte_index_nxt;
  logic [WAIT_BITS-1:0]        wait_count_r, wait_count_nxt;
  logic [hsm_pkg::VALUE_W-1:0] value_r,      value_nxt;
  logic [1:0]                  kind_r,       kind_nxt;
  logic [1:0]                  status_r,     status_nxt;

  logic [hsm_pkg::CMD_W-1:0]   command;
  logic                        recv_ack;
  logic [3:0]                  bit_count_inc;
  logic [WAIT_BITS-1:0]        wait_count_inc;
  logic [hsm_pkg::LIMIT_W-1:0] wait_limit;
  logic                        wait_expired;
  logic                        sck;
  logic                        dat;
  logic                        done;

  always_comb begin
    case (kind_r)
      hsm_pkg::KIND_TEMP:  command = cfg.temp_command;
      hsm_pkg::KIND_HUMID: command = cfg.humid_command;
      default:             command = cfg.status_command;
    endcase
  end

  assign recv_ack       = (kind_r != hsm_pkg::KIND_STATUS) && (byte_index_r < 2'd2);
  assign bit_count_inc  = bit_count_r + 4'd1;
  assign wait_count_inc = wait_count_r + WAIT_BITS'(1);
  assign wait_limit     = (kind_r == hsm_pkg::KIND_TEMP) ? cfg.temp_wait_limit
                                                         : cfg.humid_wait_limit;
  assign wait_expired   = (CW'(wait_count_r) >= CW'(wait_limit)) ||
                          (wait_count_r == WAIT_MAX);

  // line levels of the phase the item finds
  always_comb begin
    sck = 1'b0;
    dat = 1'b1;
    case (phase_r)
      PH_S1, PH_S5, PH_ACK_HI, PH_RECV_HI, PH_STOP: sck = 1'b1;
      PH_S2, PH_S4: begin
        sck = 1'b1;
        dat = 1'b0;
      end
      PH_S3:      dat = 1'b0;
      PH_SEND_LO: dat = command[3'd7 - bit_count_r[2:0]];
      PH_SEND_HI: begin
        sck = 1'b1;
        dat = command[3'd7 - bit_count_r[2:0]];
      end
      PH_RACK_LO: dat = !recv_ack;
      PH_RACK_HI: begin
        sck = 1'b1;
        dat = !recv_ack;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    byte_index_nxt = byte_index_r;
    wait_count_nxt = wait_count_r;
    value_nxt      = value_r;
    kind_nxt       = kind_r;
    status_nxt     = status_r;
    done           = 1'b0;

    if (opcode == hsm_pkg::OP_REQUEST) begin
      // a request while busy is ignored
      if (phase_r == PH_IDLE) begin
        value_nxt      = '0;
        status_nxt     = hsm_pkg::ST_OK;
        kind_nxt       = request_kind;
        bit_count_nxt  = '0;
        shift_nxt      = '0;
        byte_index_nxt = '0;
        wait_count_nxt = '0;
        if (request_kind == hsm_pkg::KIND_INVALID) begin
          status_nxt = hsm_pkg::ST_INVALID;
          done       = 1'b1;
        end else begin
          phase_nxt = PH_LEAD;
        end
      end
    end else if (phase_r != PH_IDLE) begin
      if (phase_r == PH_STOP) begin
        done = 1'b1;
      end
      case (phase_r)
        PH_LEAD: begin
          wait_count_nxt = wait_count_inc;
          if (wait_count_inc >= LEAD_TICKS) begin
            wait_count_nxt = '0;
            phase_nxt      = PH_S1;
          end
        end
        PH_S1:      phase_nxt = PH_S2;
        PH_S2:      phase_nxt = PH_S3;
        PH_S3:      phase_nxt = PH_S4;
        PH_S4:      phase_nxt = PH_S5;
        PH_S5:      phase_nxt = PH_S6;
        PH_S6: begin
          bit_count_nxt = '0;
          phase_nxt     = PH_SEND_LO;
        end
        PH_SEND_LO: phase_nxt = PH_SEND_HI;
        PH_SEND_HI: begin
          bit_count_nxt = bit_count_inc;
          phase_nxt     = (bit_count_inc >= 4'd8) ? PH_ACK_LO : PH_SEND_LO;
        end
        PH_ACK_LO:  phase_nxt = PH_ACK_HI;
        PH_ACK_HI: begin
          bit_count_nxt  = '0;
          shift_nxt      = '0;
          byte_index_nxt = '0;
          wait_count_nxt = '0;
          if (data_in) begin
            status_nxt = hsm_pkg::ST_NO_ACK;
            phase_nxt  = PH_STOP;
          end else begin
            phase_nxt = (kind_r == hsm_pkg::KIND_STATUS) ? PH_RECV_LO : PH_WAIT;
          end
        end
        PH_WAIT: begin
          // sensor pulls data low when the conversion is done
          if (!data_in) begin
            phase_nxt = PH_RECV_LO;
          end else if (wait_expired) begin
            status_nxt = hsm_pkg::ST_TIMEOUT;
            phase_nxt  = PH_RECV_LO;
          end else begin
            wait_count_nxt = wait_count_inc;
          end
        end
        PH_RECV_LO: phase_nxt = PH_RECV_HI;
        PH_RECV_HI: begin
          shift_nxt     = {shift_r[6:0], data_in};
          bit_count_nxt = bit_count_inc;
          phase_nxt     = (bit_count_inc >= 4'd8) ? PH_RACK_LO : PH_RECV_LO;
        end
        PH_RACK_LO: phase_nxt = PH_RACK_HI;
        PH_RACK_HI: begin
          if (kind_r == hsm_pkg::KIND_STATUS) begin
            value_nxt = {8'h00, shift_r};
          end else if (byte_index_r == 2'd0) begin
            value_nxt = {shift_r, 8'h00};
          end else if (byte_index_r == 2'd1) begin
            value_nxt = {value_r[15:8], shift_r};
          end
          // checksum byte is dropped
          bit_count_nxt = '0;
          if ((kind_r == hsm_pkg::KIND_STATUS) || (byte_index_r >= 2'd2)) begin
            phase_nxt = PH_STOP;
          end else begin
            byte_index_nxt = byte_index_r + 2'd1;
            shift_nxt      = '0;
            phase_nxt      = PH_RECV_LO;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      byte_index_r <= '0;
      wait_count_r <= '0;
      value_r      <= '0;
      kind_r       <= '0;
      status_r     <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      byte_index_r <= byte_index_nxt;
      wait_count_r <= wait_count_nxt;
      value_r      <= value_nxt;
      kind_r       <= kind_nxt;
      status_r     <= status_nxt;
    end
  end

  always_comb begin
    res.sck_out      = sck;
    res.data_release = dat;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.read_value   = value_nxt;
    res.status_code  = status_nxt;
  end

`ifndef SYNTHESIS
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(phase_r) && $stable(value_r) && $stable(status_r))
    else $error("sequencer state moved without an accepted item");

  a_stop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_STOP) && (opcode == hsm_pkg::OP_TICK) |=> phase_r == PH_IDLE)
    else $error("stop tick did not return to idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit count ran past one byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.done_res |=> phase_r == PH_IDLE)
    else $error("finished transaction left the sequencer busy");
`endif

endmodule

@@ hdl/hsm_out_reg.sv @@
// ----------------------------------------------------------------------------
// hsm_out_reg: result register
// Holds one result item until taken; takes a new one in the same cycle.
// ----------------------------------------------------------------------------
module hsm_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsm_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsm_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  hsm_pkg::result_t data_r;
  logic             load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ hdl/humidity_sensor_two_wire_master_core.sv @@
// ----------------------------------------------------------------------------
// humidity_sensor_two_wire_master_core: two-wire humidity sensor bus master
// Steps the start pattern, command byte, acknowledge, conversion wait and
// byte reads one half-bit tick per accepted item.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_ch    | in        | opcode, request_kind, data_in
//   out_ch   | out       | sck_out, data_release, busy_res, done_res,
//            |           | read_value, status_code
//   cfg_*    | in        | write enable, 3-bit register index, 18-bit data
//
// For each item, the sequencer forms the result from its state and the item,
// and the result register holds it the cycle after acceptance.
// An item is accepted every cycle while the result register is empty or is
// being taken; a stalled output holds one result and blocks further items.
// Synchronous reset returns the sequencer to idle and the registers to their
// reset values; there is no clearing pass.
// ----------------------------------------------------------------------------
module humidity_sensor_two_wire_master_core #(
  parameter int WAIT_BITS        = 18,
  parameter int START_LEAD_TICKS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hsm_in_if.sink                          in_ch,
  hsm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  hsm_pkg::cfg_t    cfg;
  hsm_pkg::result_t seq_res;
  hsm_pkg::result_t out_res;
  logic             in_ready;
  logic             in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  hsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hsm_seq #(
    .WAIT_BITS        (WAIT_BITS),
    .START_LEAD_TICKS (START_LEAD_TICKS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .opcode       (in_ch.opcode),
    .request_kind (in_ch.request_kind),
    .data_in      (in_ch.data_in),
    .cfg          (cfg),
    .res          (seq_res)
  );

  hsm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_data   (seq_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.sck_out      = out_res.sck_out;
  assign out_ch.data_release = out_res.data_release;
  assign out_ch.busy_res     = out_res.busy_res;
  assign out_ch.done_res     = out_res.done_res;
  assign out_ch.read_value   = out_res.read_value;
  assign out_ch.status_code  = out_res.status_code;

endmodule
